### hdl/gb3_pkg.sv
// Package for the 3x3 Gaussian blur unit: widths, types, register codes, kernel function.
`timescale 1ns / 1ps
package gb3_pkg;

  localparam int GB3_MAX_WIDTH  = 1024;
  localparam int GB3_MAX_HEIGHT = 1024;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int COORD_W        = 10;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

  localparam logic [CFG_W-1:0] IMG_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] IMG_HEIGHT_RST = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH  = 1'b0,
    CFG_IMG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pix_t               pix;
    logic               is_border;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  // 1-2-1 x 1-2-1 kernel on one channel, sum divided by 16
  function automatic logic [7:0] blur_chan(
    input logic [7:0] lt, input logic [7:0] lm, input logic [7:0] lb,
    input logic [7:0] ct, input logic [7:0] cm, input logic [7:0] cb,
    input logic [7:0] rt, input logic [7:0] rm, input logic [7:0] rb
  );
    logic [9:0]  sl;
    logic [9:0]  sc;
    logic [9:0]  sr;
    logic [11:0] tot;
    sl  = 10'(lt) + {1'b0, lm, 1'b0} + 10'(lb);
    sc  = 10'(ct) + {1'b0, cm, 1'b0} + 10'(cb);
    sr  = 10'(rt) + {1'b0, rm, 1'b0} + 10'(rb);
    tot = 12'(sl) + {1'b0, sc, 1'b0} + 12'(sr);
    return tot[11:4];
  endfunction

endpackage

### hdl/gb3_if.sv
// Stream interfaces: pixel requests in, result requests out.
`timescale 1ns / 1ps
interface gb3_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface gb3_res_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_col;
  logic [9:0] pixel_row;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       is_border;
  logic       last_of_run;

  modport source (output valid, pixel_col, pixel_row, blue_out, green_out, red_out,
                  is_border, last_of_run, input ready);
  modport sink   (input valid, pixel_col, pixel_row, blue_out, green_out, red_out,
                  is_border, last_of_run, output ready);
endinterface

### hdl/gb3_res_fifo.sv
// Result queue: takes up to two results a cycle, drives the result channel.
`timescale 1ns / 1ps
module gb3_res_fifo
  import gb3_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  push_t        push_i,
  output logic         room_o,
  gb3_res_if.source    res_o
);

  result_t                 slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    pop;
  result_t                 head;

  assign room_o = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign pop    = res_o.valid && res_o.ready;
  assign head   = slot_q[rd_ptr_q];

  assign res_o.valid       = count_q != '0;
  assign res_o.pixel_col   = head.col;
  assign res_o.pixel_row   = head.row;
  assign res_o.blue_out    = head.pix.b;
  assign res_o.green_out   = head.pix.g;
  assign res_o.red_out     = head.pix.r;
  assign res_o.is_border   = head.is_border;
  assign res_o.last_of_run = head.last_of_run;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
    count_d  = count_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      slot_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      slot_q[FIFO_PTR_W'(wr_ptr_q + FIFO_PTR_W'(1))] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hdl/gaussian_blur_3x3_rgb_unit.sv
// Top level of the 3x3 Gaussian blur unit over a raster BGR pixel stream.
//
// Pixels enter on pix_i in raster order, one request per pixel; results leave
// on res_o, each with its column and row. Border pixels come out as copies,
// interior pixels blurred with the 1-2-1 x 1-2-1 kernel once the pixel below
// and to the right arrives; when one pixel causes both, the blurred one goes
// first and last_of_run marks the final result of each pixel.
// Frame size is written on the cfg port (index 0 width, 1 height); a write
// restarts the frame at column 0, row 0. Write only while the unit is idle.
// A result passes through the stage-1 registers and the result queue before its
// valid rises; a result queue without room holds it in stage 1.
// Throughput: one pixel per cycle while the result queue has room; the result
// channel moves one result per cycle, so two-result pixels occupy it longer.
// Line store reads go through a registered memory port.
// Reset: frame size 640 x 480, counters and window cleared; the line stores
// are not cleared and need no clearing pass.
// A stalled receiver fills the four-entry result queue; pix_i.ready then drops
// and no result is lost.
`timescale 1ns / 1ps
module gaussian_blur_3x3_rgb_unit
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH  = GB3_MAX_WIDTH,
  parameter int MAX_HEIGHT = GB3_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  gb3_pix_if.sink              pix_i,
  gb3_res_if.source            res_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = CW + 1;
  localparam int HW = RW + 1;

  logic [CFG_W-1:0] img_w_q, img_h_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;

  pix_t             mem_up [MAX_WIDTH];
  pix_t             mem_mid[MAX_WIDTH];
  pix_t             rd_up_q, rd_mid_q;
  pix_t             byp_up_q, byp_mid_q;
  logic             byp_q;

  logic             s1_valid_q;
  pix_t             s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;
  pix_t             cur_up, cur_mid;

  pix_t             win_q [6];

  logic             pix_fire, s1_fire, room;
  pix_t             pix_in;
  logic             blur_en, border;
  result_t          blur_res, bord_res;
  push_t            push;

  assign pix_in   = '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
  assign s1_fire  = s1_valid_q && room;
  assign pix_i.ready = !s1_valid_q || s1_fire;
  assign pix_fire = pix_i.valid && pix_i.ready;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_WIDTH_RST;
      img_h_q <= IMG_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMG_WIDTH:  img_w_q <= cfg_data_i;
        CFG_IMG_HEIGHT: img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w_q);
    end
    if (img_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(img_h_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(img_h_q);
    end
  end

  // raster position of the next pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_fire) begin
      if (WW'(col_q) + WW'(1) >= w_eff) begin
        col_d = '0;
        if (HW'(row_q) + HW'(1) >= h_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_up[s1_col_q]  <= cur_mid;
      mem_mid[s1_col_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      rd_up_q   <= mem_up[col_q];
      rd_mid_q  <= mem_mid[col_q];
      byp_up_q  <= cur_mid;
      byp_mid_q <= s1_pix_q;
      s1_pix_q  <= pix_in;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
    end
  end

  // same-cycle write to the column being read (one-pixel rows)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (pix_fire) begin
        s1_valid_q <= 1'b1;
        byp_q      <= s1_fire && (s1_col_q == col_q);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  assign cur_up  = byp_q ? byp_up_q  : rd_up_q;
  assign cur_mid = byp_q ? byp_mid_q : rd_mid_q;

  // window: [0..2] column x-2, [3..5] column x-1; top, middle, bottom
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= cur_up;
      win_q[4] <= cur_mid;
      win_q[5] <= s1_pix_q;
    end
  end

  always_comb begin
    blur_en = (s1_col_q >= CW'(2)) && (s1_row_q >= RW'(2));
    border  = (s1_col_q == '0) || (s1_row_q == '0) ||
              (WW'(s1_col_q) + WW'(1) >= w_eff) ||
              (HW'(s1_row_q) + HW'(1) >= h_eff);

    blur_res.col   = COORD_W'(s1_col_q - CW'(1));
    blur_res.row   = COORD_W'(s1_row_q - RW'(1));
    blur_res.pix.b = blur_chan(win_q[0].b, win_q[1].b, win_q[2].b,
                               win_q[3].b, win_q[4].b, win_q[5].b,
                               cur_up.b, cur_mid.b, s1_pix_q.b);
    blur_res.pix.g = blur_chan(win_q[0].g, win_q[1].g, win_q[2].g,
                               win_q[3].g, win_q[4].g, win_q[5].g,
                               cur_up.g, cur_mid.g, s1_pix_q.g);
    blur_res.pix.r = blur_chan(win_q[0].r, win_q[1].r, win_q[2].r,
                               win_q[3].r, win_q[4].r, win_q[5].r,
                               cur_up.r, cur_mid.r, s1_pix_q.r);
    blur_res.is_border   = 1'b0;
    blur_res.last_of_run = !border;

    bord_res.col         = COORD_W'(s1_col_q);
    bord_res.row         = COORD_W'(s1_row_q);
    bord_res.pix         = s1_pix_q;
    bord_res.is_border   = 1'b1;
    bord_res.last_of_run = 1'b1;

    push.n      = s1_fire ? ({1'b0, blur_en} + {1'b0, border}) : 2'd0;
    push.first  = blur_en ? blur_res : bord_res;
    push.second = bord_res;
  end

  gb3_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("frame not restarted after size write");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_eff)
    else $error("column counter outside frame");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HW'(row_q) < h_eff)
    else $error("row counter outside frame");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> s1_valid_q)
    else $error("accepted pixel not held in stage");

endmodule
